FILE: rtl/core/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// bsmt_pkg
// Shared types and constants of the backing-store map table: table size,
// page geometry, entry layout, command codes and the result bundle.
// ----------------------------------------------------------------------------
package bsmt_pkg;

  localparam int ENTRIES    = 16;
  localparam int ENTRY_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int APAGE_W    = 32 - PAGE_SHIFT;
  localparam int DIFF_W     = 26;

  localparam logic [19:0] DEFAULT_BASE = 20'd4096;
  localparam logic signed [DIFF_W-1:0] OFFSET_MAX = DIFF_W'(1048575);
  localparam logic signed [DIFF_W-1:0] OFFSET_MIN = -DIFF_W'(1048575);

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_MAP    = 3'd4,
    CMD_UNMAP  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic        mapped;
    logic        owner_present;
    logic [7:0]  owner;
    logic [7:0]  pages;
    logic [19:0] base;
    logic        priv;
    logic        lock;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  localparam entry_t RESET_ENTRY = '{
    mapped:        1'b0,
    owner_present: 1'b0,
    owner:         8'd0,
    pages:         8'd0,
    base:          DEFAULT_BASE,
    priv:          1'b0,
    lock:          1'b0
  };

  typedef struct packed {
    logic               status;
    logic [3:0]         store_index;
    logic signed [20:0] page_offset;
  } result_t;

endpackage

FILE: rtl/core/backing_store_map_table.sv
// Clear all, map and refused commands go from the transfer straight to the
// result state; free by index reads the entry and writes it back first; find
// free, lookup and unmap scan the entry RAM read port, one entry per cycle.
// Throughput: one command at a time; the next is taken once the result moves
// to the output register. Reset clears the per-entry valid bits at once, so
// every entry reads as its default with no clearing pass.
// ----------------------------------------------------------------------------
// backing_store_map_table
// Table of backing-store entries driven by one command per transfer, with a
// registered result stage on the output channel.
// ----------------------------------------------------------------------------
module backing_store_map_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic [3:0]         entry_index,
  input  logic [7:0]         owner_id,
  input  logic [31:0]        virtual_address,
  input  logic [19:0]        virtual_page,
  input  logic [7:0]         page_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [3:0]         store_index,
  output logic signed [20:0] page_offset
);

  import bsmt_pkg::*;

  result_t res;
  logic    res_valid;
  logic    res_take;

  bsmt_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .entry_index    (entry_index),
    .owner_id       (owner_id),
    .virtual_address(virtual_address),
    .virtual_page   (virtual_page),
    .page_count     (page_count),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_take) begin
      status      <= res.status;
      store_index <= res.store_index;
      page_offset <= res.page_offset;
    end
  end

endmodule

FILE: rtl/core/bsmt_ram.sv
// ----------------------------------------------------------------------------
// bsmt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bsmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/bsmt_ctrl.sv
// ----------------------------------------------------------------------------
// bsmt_ctrl
// Command sequencer: entry RAM, per-entry valid bits, table scan with
// pipelined reads, read-modify-write for free, and result formation.
// ----------------------------------------------------------------------------
module bsmt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [3:0]        entry_index,
  input  logic [7:0]        owner_id,
  input  logic [31:0]       virtual_address,
  input  logic [19:0]       virtual_page,
  input  logic [7:0]        page_count,
  output logic              res_valid,
  input  logic              res_take,
  output bsmt_pkg::result_t res
);

  import bsmt_pkg::*;

  localparam logic [ENTRY_W-1:0] LAST = ENTRY_W'(ENTRIES - 1);

  state_t               state, state_next;
  cmd_t                 cmd_q, cmd_q_next;
  logic [ENTRY_W-1:0]   idx_q, idx_q_next;
  logic [7:0]           owner_q, owner_q_next;
  logic [APAGE_W-1:0]   apage_q, apage_q_next;
  logic [ENTRY_W-1:0]   cnt, cnt_next;
  logic                 issuing, issuing_next;
  logic                 pend_valid, pend_valid_next;
  logic [ENTRY_W-1:0]   pend_idx, pend_idx_next;
  logic [ENTRIES-1:0]   ent_valid, ent_valid_next;
  logic                 res_ok, res_ok_next;
  logic [ENTRY_W-1:0]   res_idx, res_idx_next;
  logic [19:0]          base_hit, base_hit_next;

  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_addr;
  entry_t               wr_ent;
  logic                 rd_en;
  logic [ENTRY_W-1:0]   rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  entry_t               rd_ent;
  logic                 in_range;
  logic                 hit;
  logic signed [DIFF_W-1:0] diff;
  logic signed [20:0]   offset_sat;

  bsmt_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_ent   = ent_valid[pend_idx] ? entry_t'(rd_data) : RESET_ENTRY;
  assign in_range = (32'(entry_index) < ENTRIES);
  assign hit      = pend_valid &&
                    ((cmd_q == CMD_FIND) ? !rd_ent.mapped
                                         : (rd_ent.owner_present &&
                                            rd_ent.owner == owner_q));

  assign diff = $signed(DIFF_W'(apage_q)) - $signed(DIFF_W'(base_hit));

  always_comb begin
    if (diff > OFFSET_MAX) begin
      offset_sat = 21'(OFFSET_MAX);
    end else if (diff < OFFSET_MIN) begin
      offset_sat = 21'(OFFSET_MIN);
    end else begin
      offset_sat = 21'(diff);
    end
  end

  assign in_stall        = (state != S_IDLE);
  assign res_valid       = (state == S_RESP);
  assign res.status      = !res_ok;
  assign res.store_index = res_ok ? 4'(res_idx) : 4'd0;
  assign res.page_offset = (res_ok && cmd_q == CMD_LOOKUP) ? offset_sat : 21'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issuing    <= 1'b0;
      pend_valid <= 1'b0;
      ent_valid  <= '0;
    end else begin
      state      <= state_next;
      issuing    <= issuing_next;
      pend_valid <= pend_valid_next;
      ent_valid  <= ent_valid_next;
    end
    cmd_q    <= cmd_q_next;
    idx_q    <= idx_q_next;
    owner_q  <= owner_q_next;
    apage_q  <= apage_q_next;
    cnt      <= cnt_next;
    pend_idx <= pend_idx_next;
    res_ok   <= res_ok_next;
    res_idx  <= res_idx_next;
    base_hit <= base_hit_next;
  end

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    idx_q_next      = idx_q;
    owner_q_next    = owner_q;
    apage_q_next    = apage_q;
    cnt_next        = cnt;
    issuing_next    = issuing;
    pend_valid_next = 1'b0;
    pend_idx_next   = pend_idx;
    ent_valid_next  = ent_valid;
    res_ok_next     = res_ok;
    res_idx_next    = res_idx;
    base_hit_next   = base_hit;
    wr_en           = 1'b0;
    wr_addr         = idx_q;
    wr_ent          = rd_ent;
    rd_en           = 1'b0;
    rd_addr         = cnt;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_q_next   = cmd_t'(command);
          idx_q_next   = ENTRY_W'(entry_index);
          owner_q_next = owner_id;
          apage_q_next = APAGE_W'(virtual_address >> PAGE_SHIFT);
          cnt_next     = '0;
          issuing_next = 1'b1;
          res_ok_next  = 1'b0;
          res_idx_next = '0;
          state_next   = S_RESP;
          case (cmd_t'(command))
            CMD_CLEAR: begin
              ent_valid_next = '0;
              res_ok_next    = 1'b1;
            end
            CMD_FIND, CMD_LOOKUP, CMD_UNMAP: begin
              state_next = S_SCAN;
            end
            CMD_FREE: begin
              if (in_range) begin
                state_next = S_FREE_RD;
              end
            end
            CMD_MAP: begin
              if (in_range) begin
                wr_en                 = 1'b1;
                wr_addr               = ENTRY_W'(entry_index);
                wr_ent.mapped         = 1'b1;
                wr_ent.owner_present  = 1'b1;
                wr_ent.owner          = owner_id;
                wr_ent.pages          = page_count;
                wr_ent.base           = virtual_page;
                wr_ent.priv           = 1'b0;
                wr_ent.lock           = 1'b1;
                ent_valid_next[ENTRY_W'(entry_index)] = 1'b1;
                res_ok_next           = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_en           = issuing;
        rd_addr         = cnt;
        pend_valid_next = issuing;
        pend_idx_next   = cnt;
        if (issuing) begin
          if (cnt == LAST) begin
            issuing_next = 1'b0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
        if (hit) begin
          res_ok_next     = 1'b1;
          res_idx_next    = pend_idx;
          base_hit_next   = rd_ent.base;
          pend_valid_next = 1'b0;
          issuing_next    = 1'b0;
          if (cmd_q == CMD_UNMAP) begin
            ent_valid_next[pend_idx] = 1'b0;
          end
          state_next = S_RESP;
        end else if (pend_valid && pend_idx == LAST) begin
          pend_valid_next = 1'b0;
          issuing_next    = 1'b0;
          state_next      = S_RESP;
        end
      end

      S_FREE_RD: begin
        rd_en         = 1'b1;
        rd_addr       = idx_q;
        pend_idx_next = idx_q;
        state_next    = S_FREE_WR;
      end

      S_FREE_WR: begin
        wr_en                = 1'b1;
        wr_addr              = idx_q;
        wr_ent.mapped        = 1'b0;
        wr_ent.owner_present = 1'b0;
        wr_ent.owner         = 8'd0;
        wr_ent.pages         = 8'd0;
        ent_valid_next[idx_q] = 1'b1;
        res_ok_next          = 1'b1;
        state_next           = S_RESP;
      end

      S_RESP: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/map_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_table_checker
// Watches the command and result channels of the backing-store map table. It
// keeps its own copy of every entry, works out the result that each command
// transfer must give, and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module map_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         command,
  input  logic [3:0]         entry_index,
  input  logic [7:0]         owner_id,
  input  logic [31:0]        virtual_address,
  input  logic [19:0]        virtual_page,
  input  logic [7:0]         page_count,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               status,
  input  logic [3:0]         store_index,
  input  logic signed [20:0] page_offset,
  output int                 mismatch_count,
  output int                 results_pending
);

  import bsmt_pkg::*;

  localparam int OFFSET_LIMIT = 1048575;
  localparam int REPORT_LIMIT = 10;

  entry_t  entry_model [ENTRIES];
  result_t expected_results [$];
  result_t observed;
  result_t predicted;

  function automatic int first_owned_entry(input logic [7:0] owner);
    for (int e = 0; e < ENTRIES; e++) begin
      if (entry_model[e].owner_present && entry_model[e].owner == owner) begin
        return e;
      end
    end
    return -1;
  endfunction

  function automatic result_t apply_command(input logic [2:0] cmd,
                                            input logic [3:0] idx,
                                            input logic [7:0] owner,
                                            input logic [31:0] vaddr,
                                            input logic [19:0] vpage,
                                            input logic [7:0] count);
    result_t res;
    int      hit;
    int      diff;
    res.status      = 1'b1;
    res.store_index = '0;
    res.page_offset = '0;
    case (cmd)
      CMD_CLEAR: begin
        foreach (entry_model[e]) entry_model[e] = RESET_ENTRY;
        res.status = 1'b0;
      end
      CMD_FIND: begin
        hit = -1;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
          if (!entry_model[e].mapped) hit = e;
        end
        if (hit >= 0) begin
          res.status      = 1'b0;
          res.store_index = 4'(hit);
        end
      end
      CMD_FREE: begin
        if (idx < ENTRIES) begin
          entry_model[idx].mapped        = 1'b0;
          entry_model[idx].owner_present = 1'b0;
          entry_model[idx].owner         = '0;
          entry_model[idx].pages         = '0;
          res.status = 1'b0;
        end
      end
      CMD_LOOKUP: begin
        hit = first_owned_entry(owner);
        if (hit >= 0) begin
          diff = int'(vaddr >> PAGE_SHIFT) - int'(entry_model[hit].base);
          if (diff > OFFSET_LIMIT) diff = OFFSET_LIMIT;
          if (diff < -OFFSET_LIMIT) diff = -OFFSET_LIMIT;
          res.status      = 1'b0;
          res.store_index = 4'(hit);
          res.page_offset = 21'(diff);
        end
      end
      CMD_MAP: begin
        if (idx < ENTRIES) begin
          entry_model[idx].mapped        = 1'b1;
          entry_model[idx].owner_present = 1'b1;
          entry_model[idx].owner         = owner;
          entry_model[idx].pages         = count;
          entry_model[idx].base          = vpage;
          entry_model[idx].priv          = 1'b0;
          entry_model[idx].lock          = 1'b1;
          res.status = 1'b0;
        end
      end
      CMD_UNMAP: begin
        hit = first_owned_entry(owner);
        if (hit >= 0) begin
          entry_model[hit] = RESET_ENTRY;
          res.status      = 1'b0;
          res.store_index = 4'(hit);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (entry_model[e]) entry_model[e] = RESET_ENTRY;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_command(command, entry_index, owner_id,
                                                 virtual_address, virtual_page,
                                                 page_count));
      end
      if (out_valid && !out_stall) begin
        observed.status      = status;
        observed.store_index = store_index;
        observed.page_offset = page_offset;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result with none pending: status %0d index %0d offset %0d",
                     $realtime, observed.status, observed.store_index,
                     observed.page_offset);
          end
        end else begin
          predicted = expected_results.pop_front();
          if (observed.status !== predicted.status ||
              observed.store_index !== predicted.store_index ||
              observed.page_offset !== predicted.page_offset) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch: status %0d/%0d index %0d/%0d offset %0d/%0d",
                       $realtime, observed.status, predicted.status,
                       observed.store_index, predicted.store_index,
                       observed.page_offset, predicted.page_offset);
            end
          end
        end
      end
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the backing-store map table: a directed pass that
// fills the table and hits the offset extremes, then three random phases with
// changing idle rates on both channels. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import bsmt_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO     = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI     = 3'd7;
  localparam int         RANDOM_PER_PHASE = 175;
  localparam int         SETTLE_CYCLES    = ENTRIES + 8;

  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [2:0]         command         = CMD_CLEAR;
  logic [3:0]         entry_index     = '0;
  logic [7:0]         owner_id        = '0;
  logic [31:0]        virtual_address = '0;
  logic [19:0]        virtual_page    = '0;
  logic [7:0]         page_count      = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic               status;
  logic [3:0]         store_index;
  logic signed [20:0] page_offset;

  int send_idle_pct = 27;
  int recv_idle_pct = 60;
  int mismatch_count;
  int results_pending;

  always #2 clk = ~clk;

  backing_store_map_table u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .entry_index     (entry_index),
    .owner_id        (owner_id),
    .virtual_address (virtual_address),
    .virtual_page    (virtual_page),
    .page_count      (page_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .store_index     (store_index),
    .page_offset     (page_offset)
  );

  map_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .entry_index     (entry_index),
    .owner_id        (owner_id),
    .virtual_address (virtual_address),
    .virtual_page    (virtual_page),
    .page_count      (page_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .store_index     (store_index),
    .page_offset     (page_offset),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input logic [2:0] cmd, input logic [3:0] idx,
                              input logic [7:0] owner, input logic [31:0] vaddr,
                              input logic [19:0] vpage, input logic [7:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    entry_index     <= idx;
    owner_id        <= owner;
    virtual_address <= vaddr;
    virtual_page    <= vpage;
    page_count      <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every pending result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_owner();
    if ($urandom_range(3) == 0) return 8'($urandom);
    return 8'($urandom_range(7));
  endfunction

  task automatic run_phase(input int sender_pct, input int receiver_pct);
    int         pick;
    logic [2:0] cmd;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) cmd = CMD_CLEAR;
      else if (pick < 14) cmd = CMD_FIND;
      else if (pick < 26) cmd = CMD_FREE;
      else if (pick < 48) cmd = CMD_LOOKUP;
      else if (pick < 80) cmd = CMD_MAP;
      else if (pick < 96) cmd = CMD_UNMAP;
      else cmd = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      send_command(cmd, 4'($urandom), pick_owner(), $urandom, 20'($urandom),
                   8'($urandom));
      if ($urandom_range(99) < 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the table with repeated owners, then probe it.
    send_command(CMD_FIND, '0, '0, '0, '0, '0);
    for (int e = 0; e < ENTRIES; e++) begin
      if (e == 0) send_command(CMD_MAP, 4'(e), 8'h00, '0, 20'h00000, 8'h00);
      else if (e == ENTRIES - 1) send_command(CMD_MAP, 4'(e), 8'hFF, '0, 20'hFFFFF, 8'hFF);
      else send_command(CMD_MAP, 4'(e), 8'(e % 8), '0, 20'($urandom), 8'($urandom));
    end
    send_command(CMD_FIND, '0, '0, '0, '0, '0);
    send_command(CMD_LOOKUP, '0, 8'hFF, 32'h0000_0000, '0, '0);
    send_command(CMD_LOOKUP, '0, 8'h00, 32'hFFFF_FFFF, '0, '0);
    send_command(CMD_LOOKUP, '0, 8'd200, $urandom, '0, '0);
    send_command(CMD_UNMAP, '0, 8'h00, '0, '0, '0);
    send_command(CMD_FREE, 4'hF, '0, '0, '0, '0);
    send_command(CMD_SPARE_LO, '0, '0, '0, '0, '0);
    send_command(CMD_SPARE_HI, '0, '0, '0, '0, '0);
    send_command(CMD_CLEAR, '0, '0, '0, '0, '0);

    run_phase(27, 60);
    run_phase(60, 27);
    run_phase(0, 0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bsmt_pkg.sv
rtl/core/bsmt_ram.sv
rtl/core/bsmt_ctrl.sv
rtl/core/backing_store_map_table.sv
tb/sv/map_table_checker.sv
tb/sv/testbench.sv
